// ===== rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg: shared definitions of the MSB-first bit packer
// Field widths, result codes, mode codes and parameter defaults.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int POS_W        = 16;
    localparam int CNT_W        = 7;
    localparam int VAL_W        = 64;
    localparam int NPOS_W       = 15;
    localparam int OUT_ADDR_W   = 12;
    localparam int IN_DATA_W    = 88;
    localparam int IN_USER_W    = 1;
    localparam int OUT_DATA_W   = 40;
    localparam int OUT_USER_W   = 3;
    localparam int CFG_W        = 16;

    localparam logic [CFG_W-1:0] CAP_RESET = 16'd32768;

    localparam int DEF_STORE_BYTES    = 4096;
    localparam int DEF_MAX_FIELD_BITS = 64;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_WRITE_REFUSED = 2'd1,
        ST_SEEK_REFUSED  = 2'd2
    } t_status;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_SEEK  = 1'b1
    } t_mode;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shreg_ctrl;

endpackage

// ===== rtl/mbp_digit_shreg.sv =====
// ----------------------------------------------------------------------------
// mbp_digit_shreg: byte-serial field shifter
// Holds the field bits and their mask aligned to byte boundaries of the store
// and hands out one byte of each per step, merging it into the old byte.
// ----------------------------------------------------------------------------
module mbp_digit_shreg
    import mbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic                      i_clk,
    input  t_shreg_ctrl               i_ctrl,
    input  logic [MAX_FIELD_BITS-1:0] i_value,
    input  logic [CNT_W-1:0]          i_bit_count,
    input  logic [2:0]                i_offset,
    input  logic [7:0]                i_old_byte,
    output logic [7:0]                o_new_byte
);

    localparam int SW  = MAX_FIELD_BITS + 8;
    localparam int SHW = $clog2(SW + 1);

    logic [SW-1:0]  r_data;
    logic [SW-1:0]  r_mask;
    logic [SW-1:0]  n_data;
    logic [SW-1:0]  n_mask;
    logic [SHW-1:0] w_amt;
    logic [7:0]     w_dbyte;
    logic [7:0]     w_mbyte;

    assign w_amt = SHW'(SW) - SHW'(i_offset) - SHW'(i_bit_count);

    always_comb begin
        n_data = r_data;
        n_mask = r_mask;
        if (i_ctrl.load) begin
            n_data = SW'(i_value) << w_amt;
            n_mask = (~({SW{1'b1}} << i_bit_count)) << w_amt;
        end else if (i_ctrl.shift) begin
            n_data = {r_data[SW-9:0], 8'b0};
            n_mask = {r_mask[SW-9:0], 8'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_mask <= n_mask;
    end

    assign w_dbyte    = r_data[SW-1 -: 8];
    assign w_mbyte    = r_mask[SW-1 -: 8];
    assign o_new_byte = (i_old_byte & ~w_mbyte) | (w_dbyte & w_mbyte);

endmodule

// ===== rtl/mbp_byte_store.sv =====
// ----------------------------------------------------------------------------
// mbp_byte_store: byte store of the bit packer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbp_byte_store
    import mbp_pkg::*;
#(
    parameter int STORE_BYTES = DEF_STORE_BYTES,
    parameter int MAW         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [MAW-1:0] i_waddr,
    input  logic [7:0]     i_wdata,
    input  logic [MAW-1:0] i_raddr,
    output logic [7:0]     o_rdata
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/msb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer: MSB-first bit field writer into a byte store
// Writes fields of up to MAX_FIELD_BITS bits, or seeks, and emits each
// modified byte of the store together with the resulting bit position.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel: tuser carries the mode (write or seek),
// tdata the bit count, the field value and the seek target. Results leave on
// the m_axis channel, one per modified byte for a write and a single one for
// a seek, an empty write or a refused item; tlast marks the final result of
// an item. The capacity register is written through the cfg channel, which
// is always ready, and should only be written while the block is idle.
// A write reads its first byte in S_DECIDE and then loads one result per
// touched byte in S_WRITE; any other item loads its single result in
// S_DECIDE. The next item is accepted only once the block is back in S_IDLE
// after the last result is loaded, so no item is taken before the one in
// hand is through. The byte loop does one read-modify-write of the store
// per cycle while the output register is free, with the read of the next
// byte overlapping the write of the current one.
// After reset a sweep over all STORE_BYTES bytes clears the store, during
// which no item is accepted; the position returns to zero and the capacity
// to 32768. If the receiver stalls, the block holds the pending result in
// its output register and loads nothing further; at most one more item is
// accepted and waits.
// ----------------------------------------------------------------------------
module msb_first_bit_packer
    import mbp_pkg::*;
#(
    parameter int STORE_BYTES    = DEF_STORE_BYTES,
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: bit_count[6:0], value[70:7], new_position[85:71], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: mode[0]
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: byte_address[11:0], byte_value[19:12], write_position[35:20], pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[1:0], byte_valid[2]
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready
);

    localparam int MAW       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CAP_LIMIT = STORE_BYTES * 8;
    localparam int BA_W      = POS_W - 3;
    localparam int NBW       = $clog2((MAX_FIELD_BITS + 14) / 8 + 1);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_WRITE  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cap;
    logic [POS_W-1:0]     r_pos, n_pos;
    t_mode                r_mode;
    logic [CNT_W-1:0]     r_n;
    logic [NPOS_W-1:0]    r_newpos;
    logic [BA_W-1:0]      r_addr, n_addr;
    logic [NBW-1:0]       r_nb, n_nb;
    logic [MAW-1:0]       r_clr;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic                 r_out_bv, n_out_bv;
    logic [OUT_ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [7:0]           r_out_val, n_out_val;
    logic [POS_W-1:0]     r_out_pos, n_out_pos;
    logic                 r_out_last, n_out_last;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic [POS_W:0]       w_eff_cap;
    logic [POS_W:0]       w_end;
    logic                 w_wr_refuse;
    logic                 w_seek_refuse;
    t_shreg_ctrl          w_sctrl;
    logic                 w_we;
    logic [MAW-1:0]       w_waddr;
    logic [7:0]           w_wdata;
    logic [MAW-1:0]       w_raddr;
    logic [7:0]           w_rdata;
    logic [7:0]           w_new_byte;
    logic [8:0]           w_span;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_eff_cap     = (32'(r_cap) < CAP_LIMIT) ? {1'b0, r_cap} : (POS_W+1)'(CAP_LIMIT);
    assign w_end         = (POS_W+1)'(r_pos) + (POS_W+1)'(r_n);
    assign w_wr_refuse   = (r_n > CNT_W'(MAX_FIELD_BITS)) || (w_end > w_eff_cap);
    assign w_seek_refuse = (POS_W+1)'(r_newpos) >= w_eff_cap;
    assign w_span        = 9'(r_pos[2:0]) + 9'(r_n) + 9'd7;

    assign w_sctrl.load  = w_in_acc;
    assign w_sctrl.shift = (r_state == S_WRITE) && w_out_free;

    mbp_digit_shreg #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_shreg (
        .i_clk      (i_clk),
        .i_ctrl     (w_sctrl),
        .i_value    (i_s_axis_tdata[7 +: MAX_FIELD_BITS]),
        .i_bit_count(i_s_axis_tdata[CNT_W-1:0]),
        .i_offset   (r_pos[2:0]),
        .i_old_byte (w_rdata),
        .o_new_byte (w_new_byte)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = MAW'(r_addr);
        w_wdata = w_new_byte;
        w_raddr = MAW'(r_addr);
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 8'd0;
            end
            S_DECIDE: begin
                w_raddr = MAW'(r_pos[POS_W-1:3]);
            end
            S_WRITE: begin
                w_we = w_out_free;
                if (w_out_free) begin
                    w_raddr = MAW'(r_addr + BA_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    mbp_byte_store #(
        .STORE_BYTES(STORE_BYTES),
        .MAW        (MAW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_addr       = r_addr;
        n_nb         = r_nb;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_bv     = r_out_bv;
        n_out_addr   = r_out_addr;
        n_out_val    = r_out_val;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == MAW'(STORE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_mode == MODE_WRITE && !w_wr_refuse && r_n != '0) begin
                    n_pos   = w_end[POS_W-1:0];
                    n_addr  = r_pos[POS_W-1:3];
                    n_nb    = NBW'(w_span >> 3);
                    n_state = S_WRITE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bv    = 1'b0;
                    n_out_addr  = '0;
                    n_out_val   = '0;
                    n_out_last  = 1'b1;
                    if (r_mode == MODE_SEEK) begin
                        if (w_seek_refuse) begin
                            n_out_status = ST_SEEK_REFUSED;
                        end else begin
                            n_out_status = ST_OK;
                            n_pos        = POS_W'(r_newpos);
                        end
                    end else if (w_wr_refuse) begin
                        n_out_status = ST_WRITE_REFUSED;
                    end else begin
                        n_out_status = ST_OK;
                    end
                    n_out_pos = (r_mode == MODE_SEEK && !w_seek_refuse) ?
                                POS_W'(r_newpos) : r_pos;
                    n_state   = S_IDLE;
                end
            end
            S_WRITE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_bv     = 1'b1;
                    n_out_addr   = r_addr[OUT_ADDR_W-1:0];
                    n_out_val    = w_new_byte;
                    n_out_last   = (r_nb == NBW'(1));
                    n_out_pos    = (r_nb == NBW'(1)) ? r_pos :
                                   {r_addr + BA_W'(1), 3'b000};
                    n_addr       = r_addr + BA_W'(1);
                    n_nb         = r_nb - NBW'(1);
                    if (r_nb == NBW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cap       <= CAP_RESET;
            r_pos       <= '0;
            r_clr       <= '0;
            r_nb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_nb        <= n_nb;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + MAW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_out_status <= n_out_status;
        r_out_bv     <= n_out_bv;
        r_out_addr   <= n_out_addr;
        r_out_val    <= n_out_val;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
        if (w_in_acc) begin
            r_mode   <= t_mode'(i_s_axis_tuser[0]);
            r_n      <= i_s_axis_tdata[CNT_W-1:0];
            r_newpos <= i_s_axis_tdata[71 +: NPOS_W];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = {r_out_bv, r_out_status};
    assign o_m_axis_tdata  = {(OUT_DATA_W - 36)'(0), r_out_pos, r_out_val, r_out_addr};

    // The store is never written outside the clearing sweep and the byte loop.
    a_store_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_WRITE))
        else $error("store written outside the sweep or the byte loop");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_s_axis_tready)
        else $error("item accepted during the clearing sweep");

    a_byte_loop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_nb != '0)
        else $error("byte loop entered with no bytes left");

    a_empty_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[2]) |->
        (o_m_axis_tdata[19:0] == '0 && o_m_axis_tlast))
        else $error("result without a byte carries byte fields or is not last");

    a_refused_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1:0] != ST_OK) |-> !o_m_axis_tuser[2])
        else $error("refused item reported a modified byte");

endmodule
